// File: src/mandelbrot_escape_pixel_unit_macros.svh
// ----------------------------------------------------------------------------
// Mandelbrot escape pixel unit - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_PIXEL_UNIT_MACROS_SVH
`define MANDELBROT_ESCAPE_PIXEL_UNIT_MACROS_SVH

// same-cycle implication
`define MEP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MEP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/mep_pkg.sv
// ----------------------------------------------------------------------------
// mep_pkg
// Widths, constants, types and arithmetic helpers of the escape pixel unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mep_pkg;

    localparam int COLUMN_BITS = 12;
    localparam int FRAC_BITS   = 28;
    localparam int ITER_BITS   = 16;

    localparam int VAL_BITS = FRAC_BITS + 2;        // coordinate field width
    localparam int QW       = FRAC_BITS + 4;        // Q3.F held value, signed
    localparam int SQW      = FRAC_BITS + 6;        // saturated square, unsigned
    localparam int PW       = 2 * QW;               // full product
    localparam int SUMW     = FRAC_BITS + 8;        // pre-clamp sums
    localparam int OFFW     = COLUMN_BITS + 1 + VAL_BITS;

    localparam int IDX_BITS     = 8;
    localparam int NUMW         = ITER_BITS + IDX_BITS;
    localparam int DENW         = ITER_BITS + IDX_BITS - 1;
    localparam int DIV_CNT_BITS = $clog2(IDX_BITS);

    localparam int IN_DATA_W  = ((COLUMN_BITS + VAL_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((ITER_BITS + 24 + 7) / 8) * 8;
    localparam int CFG_DATA_W = (VAL_BITS > ITER_BITS) ? VAL_BITS : ITER_BITS;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [CFG_IDX_BITS-1:0] REG_REAL_STEP = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_ITER  = 1'b1;

    localparam logic [VAL_BITS-1:0]  REAL_STEP_RST = VAL_BITS'(5) << (FRAC_BITS - 9);
    localparam logic [ITER_BITS-1:0] MAX_ITER_RST  = ITER_BITS'(256);

    typedef logic signed [QW-1:0]   q_t;
    typedef logic        [SQW-1:0]  sq_t;
    typedef logic signed [PW-1:0]   prod_t;
    typedef logic signed [SUMW-1:0] sum_t;
    typedef logic [ITER_BITS-1:0]   iter_t;

    localparam q_t Q_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam q_t Q_MIN = {1'b1, {(QW-1){1'b0}}};
    localparam q_t TWO_Q = q_t'(2) << FRAC_BITS;
    localparam sq_t SQ_MAX = {SQW{1'b1}};
    localparam logic [SQW:0] ESC_LIM = (SQW+1)'(1) << (FRAC_BITS + 2);
    localparam logic [NUMW-1:0] IDX_MAX = NUMW'(255);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        logic load;
        logic init;
        logic step;
        logic mul;
        logic sqr;
        logic div_init;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic cont;
        logic at_limit;
        logic div_last;
    } status_t;

    // floor(p / 2^F), saturated; p is a square, never negative
    function automatic sq_t sat_sq(prod_t p);
        sq_t r;
        if (|p[PW-1:PW-2])
            r = SQ_MAX;
        else
            r = p[SQW+FRAC_BITS-1:FRAC_BITS];
        return r;
    endfunction

    // floor(p / 2^(F-1)), saturated to the Q3.F range
    function automatic q_t sat_xy(prod_t p);
        logic [PW-1:0] s;
        q_t r;
        s = p >>> (FRAC_BITS - 1);
        if ((&s[PW-1:QW-1]) || !(|s[PW-1:QW-1]))
            r = q_t'(s[QW-1:0]);
        else if (s[PW-1])
            r = Q_MIN;
        else
            r = Q_MAX;
        return r;
    endfunction

    function automatic q_t clamp_sum(sum_t v);
        q_t r;
        if ((&v[SUMW-1:QW-1]) || !(|v[SUMW-1:QW-1]))
            r = q_t'(v[QW-1:0]);
        else if (v[SUMW-1])
            r = Q_MIN;
        else
            r = Q_MAX;
        return r;
    endfunction

    function automatic rgb_t palette(logic [IDX_BITS-1:0] idx, logic black);
        rgb_t c;
        logic [7:0] ramp;
        ramp = {idx[5:0], 2'b00};
        c = '0;
        if (!black)
        begin
            case (idx[7:6])
                2'b00:
                begin
                    c.green = ramp;
                    c.blue  = 8'd255;
                end
                2'b01:
                begin
                    c.green = 8'd255;
                    c.blue  = 8'd255 - ramp;
                end
                2'b10:
                begin
                    c.red   = ramp;
                    c.green = 8'd255;
                end
                default:
                begin
                    c.red   = 8'd255;
                    c.green = 8'd255 - ramp;
                end
            endcase
        end
        return c;
    endfunction

endpackage

// File: src/mandelbrot_escape_pixel_unit.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel_unit
// Escape-time Mandelbrot pixel engine with palette lookup, Q3.28 fixed point.
// ----------------------------------------------------------------------------
// One pixel is worked on at a time. Each iteration passes through S_CHECK
// (update), S_MUL (x*x, y*y and x*y in parallel) and S_SQR (scale/saturate),
// and the escape count is at most max_iterations. A request goes through
// coordinate setup (load, then S_INIT), the iteration loop with its exit
// check in S_CHECK, the restoring divider in S_DIV that forms the palette
// index, and the result load in S_DONE, which waits for a free result register.
// Points that reach the limit skip the divider and come out black. The result
// register lets the next request be taken while a finished pixel waits on
// m_axis. Write real_step and max_iterations only while the unit is idle.
`timescale 1ns / 1ps

module mandelbrot_escape_pixel_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // config write
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mep_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [mep_pkg::CFG_DATA_W-1:0]      cfg_data,
    // pixel request
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [mep_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // column, c_imag
    // pixel result
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [mep_pkg::OUT_DATA_W-1:0]      m_axis_tdata   // count, red, green, blue
);
    import mep_pkg::*;

    logic [VAL_BITS-1:0]  real_step_reg;
    logic [ITER_BITS-1:0] max_iter_reg;
    cmd_t                 cmd;
    status_t              status;
    logic [ITER_BITS-1:0] iteration_count;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            real_step_reg <= REAL_STEP_RST;
            max_iter_reg  <= MAX_ITER_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_REAL_STEP: real_step_reg <= cfg_data[VAL_BITS-1:0];
                REG_MAX_ITER:  max_iter_reg  <= cfg_data[ITER_BITS-1:0];
                default:       ;
            endcase
        end
    end

    mep_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    mep_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_column       (s_axis_tdata[COLUMN_BITS-1:0]),
        .in_c_imag       ($signed(s_axis_tdata[COLUMN_BITS +: VAL_BITS])),
        .real_step       (real_step_reg),
        .max_iterations  (max_iter_reg),
        .cmd             (cmd),
        .status          (status),
        .iteration_count (iteration_count),
        .red             (red),
        .green           (green),
        .blue            (blue)
    );

    assign m_axis_tdata = OUT_DATA_W'({blue, green, red, iteration_count});

endmodule

// File: src/mep_ctrl.sv
// ----------------------------------------------------------------------------
// mep_ctrl
// Sequencer: coordinate setup, iteration loop, palette divide, result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mandelbrot_escape_pixel_unit_macros.svh"

module mep_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  mep_pkg::status_t status,
    output mep_pkg::cmd_t    cmd
);
    import mep_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_INIT  = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_MUL   = 7'b0001000,
        S_SQR   = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.cont)
                begin
                    cmd.step   = 1'b1;
                    state_next = S_MUL;
                end
                else if (status.at_limit)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SQR;
            end
            S_SQR:
            begin
                cmd.sqr    = 1'b1;
                state_next = S_CHECK;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `MEP_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second request taken while busy")
    `MEP_ASSERT_IMP(a_no_overwrite, cmd.out_load, !out_valid_reg || out_ready, "pending result overwritten")
    `MEP_ASSERT_NEXT(a_out_held, out_valid && !out_ready, out_valid, "result dropped before taken")

endmodule

// File: src/mep_datapath.sv
// ----------------------------------------------------------------------------
// mep_datapath
// Fixed point coordinate setup, z iteration registers, restoring divider for
// the palette index, and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mandelbrot_escape_pixel_unit_macros.svh"

module mep_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [mep_pkg::COLUMN_BITS-1:0]      in_column,
    input  logic signed [mep_pkg::VAL_BITS-1:0]  in_c_imag,
    input  logic [mep_pkg::VAL_BITS-1:0]         real_step,
    input  logic [mep_pkg::ITER_BITS-1:0]        max_iterations,
    input  mep_pkg::cmd_t                        cmd,
    output mep_pkg::status_t                     status,
    output logic [mep_pkg::ITER_BITS-1:0]        iteration_count,
    output logic [7:0]                           red,
    output logic [7:0]                           green,
    output logic [7:0]                           blue
);
    import mep_pkg::*;

    logic [OFFW-1:0]         off_prod_reg;
    q_t                      ci_reg;
    q_t                      cr_reg;
    q_t                      x_reg;
    q_t                      y_reg;
    sq_t                     x2_reg;
    sq_t                     y2_reg;
    q_t                      xy_reg;
    iter_t                   it_reg;
    prod_t                   pxx_reg;
    prod_t                   pyy_reg;
    prod_t                   pxy_reg;
    logic [NUMW-1:0]         rem_reg;
    logic [DENW-1:0]         den_reg;
    logic [IDX_BITS-1:0]     quo_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    iter_t                   count_out_reg;
    rgb_t                    rgb_out_reg;

    logic [OFFW-2:0] off_sh;
    q_t              off_sat;
    q_t              cr_next;
    q_t              x_next;
    q_t              y_next;
    logic [SQW:0]    mag2;
    logic            div_ge;

    always_comb
    begin
        off_sh  = off_prod_reg[OFFW-1:1];
        off_sat = (|off_sh[OFFW-2:QW-1]) ? Q_MAX : q_t'({1'b0, off_sh[QW-2:0]});
        cr_next = off_sat - TWO_Q;
        x_next  = clamp_sum($signed({2'b00, x2_reg}) - $signed({2'b00, y2_reg})
                            + sum_t'(cr_reg));
        y_next  = clamp_sum(sum_t'(xy_reg) + sum_t'(ci_reg));
        mag2    = {1'b0, x2_reg} + {1'b0, y2_reg};
        div_ge  = NUMW'(den_reg) <= rem_reg;
    end

    assign status.cont     = (mag2 <= ESC_LIM) && (it_reg < max_iterations);
    assign status.at_limit = (it_reg == max_iterations);
    assign status.div_last = (cnt_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            off_prod_reg <= OFFW'({in_column, 1'b1}) * OFFW'(real_step);
            ci_reg       <= q_t'(in_c_imag);
        end
        if (cmd.init)
        begin
            cr_reg <= cr_next;
            x_reg  <= '0;
            y_reg  <= '0;
            x2_reg <= '0;
            y2_reg <= '0;
            xy_reg <= '0;
            it_reg <= '0;
        end
        if (cmd.step)
        begin
            x_reg  <= x_next;
            y_reg  <= y_next;
            it_reg <= it_reg + 1'b1;
        end
        if (cmd.mul)
        begin
            pxx_reg <= prod_t'(x_reg) * prod_t'(x_reg);
            pyy_reg <= prod_t'(y_reg) * prod_t'(y_reg);
            pxy_reg <= prod_t'(x_reg) * prod_t'(y_reg);
        end
        if (cmd.sqr)
        begin
            x2_reg <= sat_sq(pxx_reg);
            y2_reg <= sat_sq(pyy_reg);
            xy_reg <= sat_xy(pxy_reg);
        end
        if (cmd.div_init)
        begin
            rem_reg <= NUMW'(it_reg) * IDX_MAX;
            den_reg <= {max_iterations, {(IDX_BITS-1){1'b0}}};
            quo_reg <= '0;
            cnt_reg <= DIV_CNT_BITS'(IDX_BITS - 1);
        end
        if (cmd.div_step)
        begin
            if (div_ge)
                rem_reg <= rem_reg - NUMW'(den_reg);
            den_reg <= den_reg >> 1;
            quo_reg <= {quo_reg[IDX_BITS-2:0], div_ge};
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (cmd.out_load)
        begin
            count_out_reg <= it_reg;
            rgb_out_reg   <= palette(quo_reg, status.at_limit);
        end
    end

    assign iteration_count = count_out_reg;
    assign red             = rgb_out_reg.red;
    assign green           = rgb_out_reg.green;
    assign blue            = rgb_out_reg.blue;

    `MEP_ASSERT_NEXT(a_it_bound, cmd.step, it_reg <= max_iterations, "count passed the limit")
    `MEP_ASSERT_IMP(a_div_range, cmd.div_step, rem_reg < (NUMW'(den_reg) << 1), "quotient overflow")
    `MEP_ASSERT_IMP(a_idx_range, cmd.out_load && !status.at_limit, NUMW'(quo_reg) < IDX_MAX, "palette index out of range")

endmodule

// File: dv/tb_mandelbrot_escape_pixel_unit.sv
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_pixel_unit
// Self-checking bench for the escape-time pixel engine. Pixel requests go in
// on s_axis and results come back on m_axis. Each result is compared field by
// field against a fixed-point escape predictor. The run covers several
// real_step / max_iterations settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_mandelbrot_escape_pixel_unit;

    import mep_pkg::*;

    localparam int STALL_LIMIT = 800000;

    typedef struct packed {
        iter_t      count;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    class pixel_scoreboard;
        pixel_t              pending_pixels[$];
        logic [VAL_BITS-1:0] step_reg;
        iter_t               iter_limit;
        int                  mismatches;
        int                  checked;
        int                  in_set;

        function new();
            step_reg   = REAL_STEP_RST;
            iter_limit = MAX_ITER_RST;
            mismatches = 0;
            checked    = 0;
            in_set     = 0;
        endfunction

        function void set_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_REAL_STEP: step_reg   = data[VAL_BITS-1:0];
                REG_MAX_ITER:  iter_limit = data[ITER_BITS-1:0];
                default: ;
            endcase
        endfunction

        function longint clamp_coord(longint v);
            longint lim;
            lim = longint'(1) << (FRAC_BITS + 3);
            if (v < -lim)
                return -lim;
            if (v > lim - 1)
                return lim - 1;
            return v;
        endfunction

        // floor(a*b / 2^sh), saturated to [-lim, lim-1]
        function longint scaled_product(longint a, longint b, int sh, longint lim);
            longint q;
            q = (a * b) >>> sh;
            if (q < -lim)
                return -lim;
            if (q > lim - 1)
                return lim - 1;
            return q;
        endfunction

        function pixel_t escape_pixel(logic [COLUMN_BITS-1:0] col, logic [VAL_BITS-1:0] ci_raw);
            longint      coord_lim;
            longint      square_lim;
            longint      escape_bound;
            longint      ci;
            longint      cr;
            longint      x;
            longint      y;
            longint      x2;
            longint      y2;
            longint      nx;
            longint      ny;
            int unsigned it;
            int unsigned idx;
            pixel_t      px;
            coord_lim    = longint'(1) << (FRAC_BITS + 3);
            square_lim   = longint'(1) << (FRAC_BITS + 6);
            escape_bound = longint'(4) << FRAC_BITS;
            ci = clamp_coord(longint'($signed(ci_raw)));
            cr = scaled_product(2 * longint'(col) + 1, longint'(step_reg), 1, coord_lim);
            cr = clamp_coord(cr - (longint'(2) << FRAC_BITS));
            x  = 0;
            y  = 0;
            x2 = 0;
            y2 = 0;
            it = 0;
            while (x2 + y2 <= escape_bound && it < int'(iter_limit))
            begin
                ny = clamp_coord(scaled_product(x, y, FRAC_BITS - 1, coord_lim) + ci);
                nx = clamp_coord(x2 - y2 + cr);
                x  = nx;
                y  = ny;
                x2 = scaled_product(x, x, FRAC_BITS, square_lim);
                y2 = scaled_product(y, y, FRAC_BITS, square_lim);
                it++;
            end
            px       = '0;
            px.count = iter_t'(it);
            if (it < int'(iter_limit))
            begin
                idx = (it * 255) / int'(iter_limit);
                if (idx < 64)
                begin
                    px.green = 8'(idx * 4);
                    px.blue  = 8'd255;
                end
                else if (idx < 128)
                begin
                    px.green = 8'd255;
                    px.blue  = 8'(255 - (idx - 64) * 4);
                end
                else if (idx < 192)
                begin
                    px.red   = 8'((idx - 128) * 4);
                    px.green = 8'd255;
                end
                else
                begin
                    px.red   = 8'd255;
                    px.green = 8'(255 - (idx - 192) * 4);
                end
            end
            return px;
        endfunction

        function void note_request(logic [COLUMN_BITS-1:0] col, logic [VAL_BITS-1:0] ci_raw);
            pending_pixels.push_back(escape_pixel(col, ci_raw));
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data);
            pixel_t exp_px;
            pixel_t got_px;
            got_px.count = data[ITER_BITS-1:0];
            got_px.red   = data[ITER_BITS +: 8];
            got_px.green = data[ITER_BITS+8 +: 8];
            got_px.blue  = data[ITER_BITS+16 +: 8];
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: count=%0d rgb=%0d,%0d,%0d",
                             got_px.count, got_px.red, got_px.green, got_px.blue);
                return;
            end
            exp_px = pending_pixels.pop_front();
            checked++;
            if (exp_px.red == 0 && exp_px.green == 0 && exp_px.blue == 0)
                in_set++;
            if (got_px.count != exp_px.count || got_px.red != exp_px.red ||
                got_px.green != exp_px.green || got_px.blue != exp_px.blue)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch at %0t: exp count=%0d rgb=%0d,%0d,%0d got count=%0d rgb=%0d,%0d,%0d",
                             $realtime, exp_px.count, exp_px.red, exp_px.green, exp_px.blue,
                             got_px.count, got_px.red, got_px.green, got_px.blue);
            end
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata;   // column, c_imag
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;   // count, red, green, blue

    pixel_scoreboard sb;
    int              send_idle_pct;
    int              recv_idle_pct;
    int              recv_hold;
    int              stall_cycles;
    int              settings_run;

    mandelbrot_escape_pixel_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side: random backpressure, or a long hold when requested
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (recv_hold > 0)
            begin
                recv_hold--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_request(s_axis_tdata[COLUMN_BITS-1:0], s_axis_tdata[COLUMN_BITS +: VAL_BITS]);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic set_regime(int r);
        case (r)
            0:
            begin
                send_idle_pct = 18;
                recv_idle_pct = 62;
            end
            1:
            begin
                send_idle_pct = 62;
                recv_idle_pct = 18;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    task automatic send_pixel(int unsigned col, logic [VAL_BITS-1:0] ci);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W-COLUMN_BITS-VAL_BITS){1'b0}}, ci, COLUMN_BITS'(col)};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // stop offering requests until every outstanding pixel has come back
    task automatic drain_pixels();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_register(idx, CFG_DATA_W'(value));
    endtask

    task automatic apply_setting(int unsigned step, int unsigned iters);
        drain_pixels();
        write_reg(REG_REAL_STEP, step);
        write_reg(REG_MAX_ITER, iters);
        cfg_valid <= 1'b0;
        settings_run++;
    endtask

    function automatic logic [VAL_BITS-1:0] rand_imag();
        if ($urandom_range(99) < 75)
            return VAL_BITS'($urandom_range(0, 671088640) - 335544320);
        return VAL_BITS'($urandom());
    endfunction

    task automatic run_random_phase(int unsigned step, int unsigned iters, int count);
        int unsigned span;
        int unsigned col;
        apply_setting(step, iters);
        span = (step == 0) ? 4095 : 671088640 / step;
        if (span > 4095)
            span = 4095;
        repeat (count)
        begin
            if ($urandom_range(99) < 70)
                col = $urandom_range(0, span);
            else
                col = $urandom_range(0, 4095);
            send_pixel(col, rand_imag());
        end
    endtask

    initial
    begin
        sb            = new();
        settings_run  = 1;
        stall_cycles  = 0;
        recv_hold     = 0;
        rst_n         = 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        set_regime(0);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: interior, saturated column, cusp, imag extremes
        send_pixel(0, '0);
        send_pixel(4095, '0);
        send_pixel(128, '0);
        send_pixel(230, '0);
        send_pixel(100, VAL_BITS'(335544320));
        send_pixel(100, VAL_BITS'(-335544320));
        send_pixel(0, {1'b0, {(VAL_BITS-1){1'b1}}});
        send_pixel(4095, {1'b1, {(VAL_BITS-1){1'b0}}});
        send_pixel(150, VAL_BITS'(161061273));
        send_pixel(180, VAL_BITS'(80530636));

        // widest step, deepest limit
        apply_setting(671088640, 65535);
        send_pixel(4095, '0);
        send_pixel(0, '0);
        send_pixel(1, '0);
        send_pixel(0, VAL_BITS'(335544320));

        // zero step, zero limit
        apply_setting(0, 0);
        send_pixel(0, '0);
        send_pixel(4095, {1'b0, {(VAL_BITS-1){1'b1}}});

        apply_setting(0, 1);
        send_pixel(77, '0);
        send_pixel(5, {1'b0, {(VAL_BITS-1){1'b1}}});

        apply_setting(1, 7);
        send_pixel(4095, '0);
        send_pixel(2000, VAL_BITS'(100000000));

        // long result-side hold while requests keep coming
        drain_pixels();
        recv_hold = 600;
        run_random_phase(2621440, 64, 300);
        run_random_phase(1048576, 128, 250);
        run_random_phase(671088640, 20, 200);

        set_regime(1);
        run_random_phase(1, 16, 150);
        run_random_phase($urandom_range(262144, 8388608), 255, 250);
        run_random_phase($urandom_range(1, 671088640), 1, 150);

        set_regime(2);
        run_random_phase(0, 40, 100);
        run_random_phase($urandom_range(1048576, 4194304), 100, 300);
        run_random_phase($urandom_range(1, 16777216), $urandom_range(2, 300), 250);

        drain_pixels();
        repeat (40) @(posedge clk);

        $display("checked %0d pixels over %0d register settings, %0d of them black",
                 sb.checked, settings_run, sb.in_set);
        $display("mismatches: %0d, results still outstanding: %0d", sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/mep_pkg.sv
src/mep_ctrl.sv
src/mep_datapath.sv
src/mandelbrot_escape_pixel_unit.sv
dv/tb_mandelbrot_escape_pixel_unit.sv
